>>> design/bdlp_pkg.sv
// Package for the button debouncer with long-press detection.
// Holds the event codes, register indexes, reset values and field widths.
// No dependencies; every other design file uses it by scoped names.
package bdlp_pkg;

    localparam int NUM_PLAIN_BUTTONS_DEFAULT = 3;
    localparam int LEVEL_FIELDS = 3;

    localparam int DEBOUNCE_W = 8;
    localparam int HOLD_W = 16;
    localparam int EVENT_W = 3;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd5;
    localparam logic [HOLD_W-1:0] LONG_PRESS_RESET = 16'd300;
    localparam logic [DEBOUNCE_W-1:0] COUNT_MAX = 8'hFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEBOUNCE_TICKS = 1'b0,
        REG_LONG_PRESS_TICKS = 1'b1
    } cfg_reg_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE = 3'd0,
        EV_START = 3'd1,
        EV_STOP = 3'd2,
        EV_REVERSE = 3'd3,
        EV_RESET_SHORT = 3'd4,
        EV_RESET_LONG = 3'd5
    } event_t;

    typedef enum logic {
        MODE_POLL = 1'b0,
        MODE_FETCH = 1'b1
    } mode_t;

endpackage

>>> design/bdlp_if.sv
// Valid/ready channel interfaces for the button debouncer.
// Input items, result items and configuration writes; uses bdlp_pkg widths.
interface bdlp_item_if;
    logic valid;
    logic ready;
    logic mode;
    logic start_level;
    logic stop_level;
    logic reverse_level;
    logic reset_level;

    modport source (output valid, output mode, output start_level, output stop_level,
                    output reverse_level, output reset_level, input ready);
    modport sink (input valid, input mode, input start_level, input stop_level,
                  input reverse_level, input reset_level, output ready);
endinterface

interface bdlp_result_if;
    logic valid;
    logic ready;
    logic [bdlp_pkg::EVENT_W-1:0] event_code;

    modport source (output valid, output event_code, input ready);
    modport sink (input valid, input event_code, output ready);
endinterface

interface bdlp_cfg_if;
    logic valid;
    logic ready;
    logic [bdlp_pkg::CFG_INDEX_W-1:0] index;
    logic [bdlp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/button_debounce_long_press.sv
// Button debouncer with press events and long-press detection on the reset button.
// Depends on bdlp_pkg and the channel interfaces in bdlp_if.sv.
//
// Usage: each beat on items is either a poll tick (mode 0) carrying the start,
// stop, reverse and reset levels, or a fetch (mode 1) that reads and clears the
// event latch. Every item gives exactly one beat on results: the latched event
// for a fetch, zero for a poll tick. The cfg channel writes debounce_ticks
// (index 0) and long_press_ticks (index 1); it is always ready. The user must
// write it only while the block is idle; the block itself does not enforce this.
// An accepted item passes through the input register, then the state update and
// result register, to its result beat. An item may be accepted every cycle while
// results does not stall; the state update itself is combinational.
// When results stalls, the result register holds its beat and the input
// register holds one more item; items then deasserts ready until results moves.
// Reset clears all counters and flags, empties the event latch and both
// stages, and restores debounce_ticks to 5 and long_press_ticks to 300.
module button_debounce_long_press #(
    parameter int NUM_PLAIN_BUTTONS = bdlp_pkg::NUM_PLAIN_BUTTONS_DEFAULT
) (
    input logic clk,
    input logic rst_n,
    bdlp_item_if.sink items,
    bdlp_result_if.source results,
    bdlp_cfg_if.sink cfg
);

    localparam int DW = bdlp_pkg::DEBOUNCE_W;
    localparam int HW = bdlp_pkg::HOLD_W;
    localparam int EW = bdlp_pkg::EVENT_W;
    localparam int LF = bdlp_pkg::LEVEL_FIELDS;

    logic [DW-1:0] debounce_reg;
    logic [HW-1:0] long_press_reg;

    logic s1_valid_reg;
    logic s1_mode_reg;
    logic [LF-1:0] s1_levels_reg;
    logic s1_reset_level_reg;

    logic out_valid_reg;
    logic [EW-1:0] out_code_reg;
    logic [EW-1:0] out_code_next;

    logic [NUM_PLAIN_BUTTONS-1:0] last_reg;
    logic [NUM_PLAIN_BUTTONS-1:0] last_next;
    logic [DW-1:0] count_reg [NUM_PLAIN_BUTTONS];
    logic [DW-1:0] count_next [NUM_PLAIN_BUTTONS];
    logic [NUM_PLAIN_BUTTONS-1:0] reported_reg;
    logic [NUM_PLAIN_BUTTONS-1:0] reported_next;

    logic rst_last_reg;
    logic rst_last_next;
    logic [DW-1:0] rst_count_reg;
    logic [DW-1:0] rst_count_next;
    logic [HW-1:0] hold_reg;
    logic [HW-1:0] hold_next;
    logic long_done_reg;
    logic long_done_next;
    logic [EW-1:0] latch_reg;
    logic [EW-1:0] latch_next;

    logic s2_free;
    logic s1_advance;
    logic [NUM_PLAIN_BUTTONS+LF-1:0] padded_levels;
    logic [NUM_PLAIN_BUTTONS-1:0] plain_levels;

    assign s2_free = !out_valid_reg || results.ready;
    assign s1_advance = s1_valid_reg && s2_free;
    assign items.ready = !s1_valid_reg || s2_free;
    assign cfg.ready = 1'b1;
    assign results.valid = out_valid_reg;
    assign results.event_code = out_code_reg;

    // Plain buttons without a level field read as released.
    assign padded_levels = {{NUM_PLAIN_BUTTONS{1'b0}}, s1_levels_reg};
    assign plain_levels = padded_levels[NUM_PLAIN_BUTTONS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= bdlp_pkg::DEBOUNCE_RESET;
            long_press_reg <= bdlp_pkg::LONG_PRESS_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (bdlp_pkg::cfg_reg_t'(cfg.index))
                bdlp_pkg::REG_DEBOUNCE_TICKS: debounce_reg <= cfg.data[DW-1:0];
                bdlp_pkg::REG_LONG_PRESS_TICKS: long_press_reg <= cfg.data[HW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            s1_mode_reg <= items.mode;
            s1_levels_reg <= {items.reverse_level, items.stop_level, items.start_level};
            s1_reset_level_reg <= items.reset_level;
        end
        if (s1_advance)
        begin
            out_code_reg <= out_code_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (items.ready)
            begin
                s1_valid_reg <= items.valid;
            end
            if (s2_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_comb
    begin
        last_next = last_reg;
        count_next = count_reg;
        reported_next = reported_reg;
        rst_last_next = rst_last_reg;
        rst_count_next = rst_count_reg;
        hold_next = hold_reg;
        long_done_next = long_done_reg;
        latch_next = latch_reg;
        out_code_next = bdlp_pkg::EV_NONE;

        if (s1_mode_reg == bdlp_pkg::MODE_FETCH)
        begin
            out_code_next = latch_reg;
            latch_next = bdlp_pkg::EV_NONE;
        end
        else
        begin
            // Buttons are visited in order so the last event written wins.
            for (int i = 0; i < NUM_PLAIN_BUTTONS; i++)
            begin
                if (plain_levels[i] != last_reg[i])
                begin
                    count_next[i] = '0;
                    last_next[i] = plain_levels[i];
                end
                else if (plain_levels[i])
                begin
                    if (count_reg[i] != bdlp_pkg::COUNT_MAX)
                    begin
                        count_next[i] = count_reg[i] + 1'b1;
                    end
                    if (count_next[i] >= debounce_reg && !reported_reg[i])
                    begin
                        reported_next[i] = 1'b1;
                        latch_next = EW'(i + 1);
                    end
                end
                else
                begin
                    count_next[i] = '0;
                    reported_next[i] = 1'b0;
                end
            end

            if (s1_reset_level_reg)
            begin
                if (!rst_last_reg)
                begin
                    rst_count_next = '0;
                    rst_last_next = 1'b1;
                    hold_next = '0;
                    long_done_next = 1'b0;
                end
                else
                begin
                    if (rst_count_reg < debounce_reg)
                    begin
                        rst_count_next = rst_count_reg + 1'b1;
                    end
                    if (rst_count_next >= debounce_reg)
                    begin
                        if (hold_reg < long_press_reg)
                        begin
                            hold_next = hold_reg + 1'b1;
                        end
                        if (hold_next >= long_press_reg && !long_done_reg)
                        begin
                            latch_next = bdlp_pkg::EV_RESET_LONG;
                            long_done_next = 1'b1;
                        end
                    end
                end
            end
            else
            begin
                if (rst_last_reg && !long_done_reg)
                begin
                    latch_next = bdlp_pkg::EV_RESET_SHORT;
                end
                rst_count_next = '0;
                rst_last_next = 1'b0;
                hold_next = '0;
                long_done_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
            reported_reg <= '0;
            for (int i = 0; i < NUM_PLAIN_BUTTONS; i++)
            begin
                count_reg[i] <= '0;
            end
            rst_last_reg <= 1'b0;
            rst_count_reg <= '0;
            hold_reg <= '0;
            long_done_reg <= 1'b0;
            latch_reg <= bdlp_pkg::EV_NONE;
        end
        else if (s1_advance)
        begin
            last_reg <= last_next;
            reported_reg <= reported_next;
            count_reg <= count_next;
            rst_last_reg <= rst_last_next;
            rst_count_reg <= rst_count_next;
            hold_reg <= hold_next;
            long_done_reg <= long_done_next;
            latch_reg <= latch_next;
        end
    end

endmodule

>>> tb/sv/button_debounce_long_press_tb.sv
// Self-checking testbench for button_debounce_long_press: directed rows, then random
// press sequences under several register settings and handshake idle patterns.
// Depends on bdlp_pkg and the channel interfaces in design/bdlp_if.sv.
module button_debounce_long_press_tb;

    localparam int PLAIN = bdlp_pkg::NUM_PLAIN_BUTTONS_DEFAULT;
    localparam int RST_IDX = PLAIN;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD_TICKS = 260;

    typedef struct packed {
        bdlp_pkg::mode_t mode;
        logic [3:0] lv;
    } tick_t;

    typedef enum logic [1:0] {
        ROW_POLL,
        ROW_FETCH,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        logic [3:0] lv;
        int reps;
        bdlp_pkg::event_t want;
        bdlp_pkg::cfg_reg_t idx;
        logic [15:0] val;
    } dir_row_t;

    typedef struct packed {
        logic [7:0] debounce;
        logic [15:0] long_ticks;
        int send_pct;
        int stall_pct;
        int items;
        int pause;
    } phase_t;

    logic clk;
    logic rst_n;

    bdlp_item_if items_ch();
    bdlp_result_if result_ch();
    bdlp_cfg_if cfg_ch();

    button_debounce_long_press uut (
        .clk(clk),
        .rst_n(rst_n),
        .items(items_ch),
        .results(result_ch),
        .cfg(cfg_ch)
    );

    logic [7:0] cfg_debounce = bdlp_pkg::DEBOUNCE_RESET;
    logic [15:0] cfg_long = bdlp_pkg::LONG_PRESS_RESET;
    logic btn_level [0:PLAIN];
    logic [7:0] btn_stable [0:PLAIN];
    logic btn_fired [0:PLAIN-1];
    logic [15:0] rst_hold = '0;
    logic rst_long_seen = 1'b0;
    bdlp_pkg::event_t held_event = bdlp_pkg::EV_NONE;

    bdlp_pkg::event_t due_codes [$];
    bdlp_pkg::event_t want_code;
    dir_row_t script [$];
    phase_t plan [7];

    logic [3:0] gen_lv = '0;
    int gen_run = 0;
    int send_pct = 0;
    int stall_pct = 0;
    int hold_off = 0;
    int idle_cycles = 0;
    int errors = 0;
    int checked = 0;
    int items_sent = 0;
    int events_seen = 0;
    int reg_writes = 0;
    int backpressure = 0;

    initial
    begin
        clk = 1'b0;
        for (int i = 0; i <= PLAIN; i++)
        begin
            btn_level[i] = 1'b0;
            btn_stable[i] = '0;
        end
        for (int i = 0; i < PLAIN; i++)
            btn_fired[i] = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic bdlp_pkg::event_t predict_event(input tick_t t);
        bdlp_pkg::event_t code;
        logic lvl;
        code = bdlp_pkg::EV_NONE;
        if (t.mode == bdlp_pkg::MODE_FETCH)
        begin
            code = held_event;
            held_event = bdlp_pkg::EV_NONE;
            return code;
        end
        for (int i = 0; i < PLAIN; i++)
        begin
            lvl = (i < bdlp_pkg::LEVEL_FIELDS) ? t.lv[i] : 1'b0;
            if (lvl != btn_level[i])
            begin
                btn_stable[i] = '0;
                btn_level[i] = lvl;
            end
            else if (lvl)
            begin
                if (btn_stable[i] < bdlp_pkg::COUNT_MAX)
                    btn_stable[i] = btn_stable[i] + 8'd1;
                if (btn_stable[i] >= cfg_debounce && !btn_fired[i])
                begin
                    btn_fired[i] = 1'b1;
                    held_event = bdlp_pkg::event_t'(i + 1);
                end
            end
            else
            begin
                btn_stable[i] = '0;
                btn_fired[i] = 1'b0;
            end
        end
        if (t.lv[3])
        begin
            if (!btn_level[RST_IDX])
            begin
                btn_stable[RST_IDX] = '0;
                btn_level[RST_IDX] = 1'b1;
                rst_hold = '0;
                rst_long_seen = 1'b0;
            end
            else
            begin
                if (btn_stable[RST_IDX] < cfg_debounce)
                    btn_stable[RST_IDX] = btn_stable[RST_IDX] + 8'd1;
                if (btn_stable[RST_IDX] >= cfg_debounce)
                begin
                    if (rst_hold < cfg_long)
                        rst_hold = rst_hold + 16'd1;
                    if (rst_hold >= cfg_long && !rst_long_seen)
                    begin
                        held_event = bdlp_pkg::EV_RESET_LONG;
                        rst_long_seen = 1'b1;
                    end
                end
            end
        end
        else
        begin
            if (btn_level[RST_IDX] && !rst_long_seen)
                held_event = bdlp_pkg::EV_RESET_SHORT;
            btn_stable[RST_IDX] = '0;
            btn_level[RST_IDX] = 1'b0;
            rst_hold = '0;
            rst_long_seen = 1'b0;
        end
        return bdlp_pkg::EV_NONE;
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        int d;
        int h;
        int pick;
        d = cfg_debounce;
        h = (cfg_long > 16'd300) ? 300 : int'(cfg_long);
        t.mode = bdlp_pkg::MODE_POLL;
        t.lv = gen_lv;
        if ($urandom_range(99) < 12)
        begin
            t.mode = bdlp_pkg::MODE_FETCH;
            t.lv = 4'($urandom);
            return t;
        end
        if ($urandom_range(99) < 8)
        begin
            t.lv = gen_lv ^ 4'($urandom_range(1, 15));
            return t;
        end
        if (gen_run <= 0)
        begin
            if ($urandom_range(3) == 0)
                gen_lv = 4'($urandom);
            else
                gen_lv = gen_lv ^ (4'b0001 << $urandom_range(0, 3));
            pick = $urandom_range(9);
            if (pick < 4)
                gen_run = $urandom_range(1, d + 1);
            else if (pick < 7)
                gen_run = d + $urandom_range(0, 3);
            else
                gen_run = d + 1 + $urandom_range(1, h + 3);
            if (gen_run < 1)
                gen_run = 1;
            t.lv = gen_lv;
        end
        gen_run--;
        return t;
    endfunction

    function automatic dir_row_t poll_row(input logic [3:0] lv, input int reps);
        return '{ROW_POLL, lv, reps, bdlp_pkg::EV_NONE, bdlp_pkg::REG_DEBOUNCE_TICKS, 16'd0};
    endfunction

    function automatic dir_row_t fetch_row(input logic [3:0] lv,
                                           input bdlp_pkg::event_t want);
        return '{ROW_FETCH, lv, 1, want, bdlp_pkg::REG_DEBOUNCE_TICKS, 16'd0};
    endfunction

    function automatic dir_row_t cfg_row(input bdlp_pkg::cfg_reg_t idx,
                                         input logic [15:0] val);
        return '{ROW_CFG, 4'd0, 0, bdlp_pkg::EV_NONE, idx, val};
    endfunction

    task automatic offer_item(input tick_t t, input bit typed,
                              input bdlp_pkg::event_t want);
        bdlp_pkg::event_t code;
        while ($urandom_range(99) < send_pct)
        begin
            items_ch.valid = 1'b0;
            @(negedge clk);
        end
        items_ch.valid = 1'b1;
        items_ch.mode = t.mode;
        items_ch.start_level = t.lv[0];
        items_ch.stop_level = t.lv[1];
        items_ch.reverse_level = t.lv[2];
        items_ch.reset_level = t.lv[3];
        @(posedge clk);
        while (!items_ch.ready)
            @(posedge clk);
        code = predict_event(t);
        if (t.mode == bdlp_pkg::MODE_FETCH && code != bdlp_pkg::EV_NONE)
            events_seen++;
        due_codes.push_back(typed ? want : code);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        items_ch.valid = 1'b0;
        while (due_codes.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input bdlp_pkg::cfg_reg_t idx, input logic [15:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data = val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx == bdlp_pkg::REG_DEBOUNCE_TICKS)
            cfg_debounce = val[7:0];
        else
            cfg_long = val;
        reg_writes++;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            result_ch.ready = 1'b0;
            hold_off--;
        end
        else
            result_ch.ready = ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            checked++;
            if (due_codes.size() == 0)
            begin
                errors++;
                $error("event_code beat with nothing expected: actual %0d",
                       result_ch.event_code);
            end
            else
            begin
                want_code = due_codes.pop_front();
                if (result_ch.event_code !== want_code)
                begin
                    errors++;
                    $error("event_code mismatch: expected %0d, actual %0d",
                           want_code, result_ch.event_code);
                end
            end
        end
        if (rst_n && items_ch.valid && !items_ch.ready)
            backpressure++;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((items_ch.valid && items_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        items_ch.valid = 1'b0;
        items_ch.mode = bdlp_pkg::MODE_POLL;
        items_ch.start_level = 1'b0;
        items_ch.stop_level = 1'b0;
        items_ch.reverse_level = 1'b0;
        items_ch.reset_level = 1'b0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = bdlp_pkg::REG_DEBOUNCE_TICKS;
        cfg_ch.data = '0;

        script.push_back(fetch_row(4'b0000, bdlp_pkg::EV_NONE));
        script.push_back(poll_row(4'b0001, 6));
        script.push_back(fetch_row(4'b0000, bdlp_pkg::EV_START));
        script.push_back(fetch_row(4'b0000, bdlp_pkg::EV_NONE));
        script.push_back(cfg_row(bdlp_pkg::REG_DEBOUNCE_TICKS, 16'd1));
        script.push_back(cfg_row(bdlp_pkg::REG_LONG_PRESS_TICKS, 16'd2));
        script.push_back(poll_row(4'b1111, 2));
        script.push_back(fetch_row(4'b0000, bdlp_pkg::EV_REVERSE));
        script.push_back(poll_row(4'b1111, 1));
        script.push_back(fetch_row(4'b0000, bdlp_pkg::EV_RESET_LONG));
        script.push_back(poll_row(4'b0000, 1));
        script.push_back(fetch_row(4'b0000, bdlp_pkg::EV_NONE));
        script.push_back(poll_row(4'b1000, 2));
        script.push_back(poll_row(4'b0000, 1));
        script.push_back(fetch_row(4'b1111, bdlp_pkg::EV_RESET_SHORT));
        script.push_back(cfg_row(bdlp_pkg::REG_DEBOUNCE_TICKS, 16'd0));
        script.push_back(cfg_row(bdlp_pkg::REG_LONG_PRESS_TICKS, 16'd0));
        script.push_back(poll_row(4'b1001, 2));
        script.push_back(fetch_row(4'b0000, bdlp_pkg::EV_RESET_LONG));
        script.push_back(poll_row(4'b0111, 2));

        plan[0] = '{8'd3, 16'd8, 0, 0, 30, 0};
        plan[1] = '{8'd2, 16'd20, 72, 0, 30, 0};
        plan[2] = '{8'd1, 16'd1, 0, 72, 30, 0};
        plan[3] = '{8'd0, 16'd0, 11, 11, 25, 0};
        plan[4] = '{8'd255, 16'd4, 0, 0, 20, 0};
        plan[5] = '{8'd4, 16'd12, 0, 0, 40, 200};
        plan[6] = '{8'd2, 16'd6, 11, 11, 25, 0};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (script[r])
        begin
            case (script[r].kind)
                ROW_CFG:
                begin
                    drain();
                    write_reg(script[r].idx, script[r].val);
                end
                ROW_FETCH:
                    offer_item('{bdlp_pkg::MODE_FETCH, script[r].lv}, 1'b1, script[r].want);
                default:
                    repeat (script[r].reps)
                        offer_item('{bdlp_pkg::MODE_POLL, script[r].lv}, 1'b0,
                                   bdlp_pkg::EV_NONE);
            endcase
        end

        foreach (plan[p])
        begin
            drain();
            write_reg(bdlp_pkg::REG_DEBOUNCE_TICKS, {8'd0, plan[p].debounce});
            write_reg(bdlp_pkg::REG_LONG_PRESS_TICKS, plan[p].long_ticks);
            send_pct = plan[p].send_pct;
            stall_pct = plan[p].stall_pct;
            hold_off = plan[p].pause;
            repeat (plan[p].items)
                offer_item(random_tick(), 1'b0, bdlp_pkg::EV_NONE);
        end

        drain();
        write_reg(bdlp_pkg::REG_DEBOUNCE_TICKS, 16'd1);
        write_reg(bdlp_pkg::REG_LONG_PRESS_TICKS, 16'hFFFF);
        send_pct = 0;
        stall_pct = 0;
        repeat (LONG_HOLD_TICKS)
            offer_item('{bdlp_pkg::MODE_POLL, 4'b1111}, 1'b0, bdlp_pkg::EV_NONE);
        offer_item('{bdlp_pkg::MODE_POLL, 4'b0000}, 1'b0, bdlp_pkg::EV_NONE);
        offer_item('{bdlp_pkg::MODE_FETCH, 4'b0000}, 1'b0, bdlp_pkg::EV_NONE);
        repeat (20)
            offer_item(random_tick(), 1'b0, bdlp_pkg::EV_NONE);

        drain();
        repeat (8) @(negedge clk);
        if (due_codes.size() != 0)
        begin
            errors++;
            $error("%0d expected event_code beats never arrived", due_codes.size());
        end

        $display("Run covered %0d items, %0d checked result beats and %0d register writes.",
                 items_sent, checked, reg_writes);
        $display("Fetches returned %0d events; the input was held off for %0d cycles.",
                 events_seen, backpressure);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
